>>> hdl/sipq_pkg.sv
// shared types and codes for the sorted-insert priority queue
`timescale 1ns / 1ps

package sipq_pkg;

    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [VALUE_W-1:0]  value_t;

    // result status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

endpackage

>>> hdl/sipq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sipq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sorted_insert_priority_queue_core.sv
// sorted-insert priority queue: ascending store of signed values, insert and pop-min
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed 32-bit values in ascending order in one ram,
// used as a ring with a head pointer so that a remove only moves the head.
// An insert (op 0) walks from the tail toward the head, one stored value per
// step: each step reads one entry, compares it with the new value in the one
// shared signed comparator and either moves the entry up one slot or writes
// the new value into the hole. A new value lands in front of equal values.
// A remove (op 1) reads the head entry and returns it. Every transaction on
// the input gives exactly one result transaction with a status (done, remove
// on empty, insert dropped because full), the removed value (zero unless a
// remove succeeded) and the low five bits of the entry count afterwards.
// Timing: the block takes one item at a time and drops s_ready while working.
// A rejected item goes straight to the result step; a remove reads the head
// and then takes its value; an insert moves each stored value not smaller
// than the new one up one slot, each such entry taking a read step and a
// compare/write step on the single ram port pair. The result sits in an
// output register, so the next item can be accepted while it waits for
// m_ready. The store needs no clearing after reset: only entries below the
// count are ever read, and each of those has been written.

module sorted_insert_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic signed [sipq_pkg::VALUE_W-1:0]  s_value,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sipq_pkg::STATUS_W-1:0]        m_status,
    output logic signed [sipq_pkg::VALUE_W-1:0]  m_removed_value,
    output logic [sipq_pkg::ENTRY_COUNT_W-1:0]   m_entry_count
);

    // address and count widths follow from the capacity
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = sipq_pkg::ENTRY_COUNT_W;

    localparam logic [AW:0]   CAP_SUM   = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [AW-1:0] HEAD_LAST = AW'(CAPACITY - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;  // issue ram read
    localparam logic [2:0] S_CMP  = 3'd2;  // compare and shift or place
    localparam logic [2:0] S_POP  = 3'd3;  // take head value
    localparam logic [2:0] S_FIN  = 3'd4;  // hand result to output register

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    op_reg, op_next;
    sipq_pkg::value_t        value_reg, value_next;
    sipq_pkg::status_t       res_status_reg, res_status_next;
    sipq_pkg::value_t        res_value_reg, res_value_next;

    logic                    m_valid_reg, m_valid_next;
    sipq_pkg::status_t       m_status_reg, m_status_next;
    sipq_pkg::value_t        m_value_reg, m_value_next;
    logic [EW-1:0]           m_count_reg, m_count_next;

    // ram port signals
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    sipq_pkg::value_t        ram_wdata;
    logic [AW-1:0]           ram_raddr;
    sipq_pkg::value_t        ram_rdata;

    // ring address arithmetic: logical index plus head, wrapped once
    logic [CW-1:0]           rd_k;
    logic [AW:0]             rd_sum, rd_wrap;
    logic [AW:0]             wr_sum, wr_wrap;
    logic [CW+EW-1:0]        count_ext;

    logic                    s_fire;
    logic                    out_free;
    logic                    move_up;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // insert reads the entry just below the hole, remove reads the head
    assign rd_k    = (op_reg == sipq_pkg::OP_REMOVE) ? '0 : idx_reg - 1'b1;
    assign rd_sum  = {1'b0, head_reg} + {1'b0, rd_k[AW-1:0]};
    assign rd_wrap = (rd_sum >= CAP_SUM) ? rd_sum - CAP_SUM : rd_sum;
    assign wr_sum  = {1'b0, head_reg} + {1'b0, idx_reg[AW-1:0]};
    assign wr_wrap = (wr_sum >= CAP_SUM) ? wr_sum - CAP_SUM : wr_sum;

    assign ram_raddr = rd_wrap[AW-1:0];
    assign ram_waddr = wr_wrap[AW-1:0];

    // the shared comparator: stored entry not smaller than the new value moves up
    assign move_up = $signed(ram_rdata) >= $signed(value_reg);

    assign count_ext = {{EW{1'b0}}, count_next};

    sipq_ram #(
        .WIDTH (sipq_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_count_next    = m_count_reg;
        ram_we          = 1'b0;
        ram_wdata       = value_reg;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_next         = s_op;
                    value_next      = s_value;
                    idx_next        = count_reg;
                    res_status_next = sipq_pkg::ST_DONE;
                    res_value_next  = '0;
                    if (s_op == sipq_pkg::OP_INSERT) begin
                        if (count_reg == CAP_COUNT) begin
                            res_status_next = sipq_pkg::ST_FULL;
                            state_next      = S_FIN;
                        end else begin
                            state_next = S_READ;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = sipq_pkg::ST_EMPTY;
                            state_next      = S_FIN;
                        end else begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                if (op_reg == sipq_pkg::OP_REMOVE) begin
                    state_next = S_POP;
                end else if (idx_reg == '0) begin
                    // hole reached the head: place the new value there
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ram_we = 1'b1;
                if (move_up) begin
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_READ;
                end else begin
                    count_next = count_reg + 1'b1;
                    state_next = S_FIN;
                end
            end
            S_POP: begin
                res_value_next = ram_rdata;
                head_next      = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
                count_next     = count_reg - 1'b1;
                state_next     = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_count_next  = count_ext[EW-1:0];
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and work registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_count_reg    <= m_count_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_removed_value = m_value_reg;
    assign m_entry_count   = m_count_reg;

`ifndef SYNTHESIS
    // the store never holds more than its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_COUNT)
        else $error("entry count above capacity");

    // the store is only written while an insert is being worked on
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (op_reg == sipq_pkg::OP_INSERT && state_reg != S_IDLE))
        else $error("ram write outside an insert");

    // one item at a time: no acceptance in the cycle after an acceptance
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input accepted while busy");

    // a rejected or failed item never reports a removed value
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == sipq_pkg::ST_FULL || m_status == sipq_pkg::ST_EMPTY))
        |-> (m_removed_value == '0))
        else $error("nonzero value on a failed item");
`endif

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the sorted-insert priority queue core
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY    = 16;
    localparam int IDLE_PCT    = 38;
    localparam int RANDOM_ITEMS = 650;
    // keep some margin after the last result, scaled with the capacity
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 10;

    typedef logic [sipq_pkg::ENTRY_COUNT_W-1:0] count_t;

    // one predicted result transaction
    typedef struct packed {
        sipq_pkg::status_t status;
        sipq_pkg::value_t  removed_value;
        count_t            entry_count;
    } queue_result_t;

    // tracks the sorted store and the results it must produce, in order
    class sorted_store_tracker;
        int            capacity;
        int            held_values[$];
        queue_result_t awaited_results[$];
        int            mismatches;

        function new(int cap);
            capacity   = cap;
            mismatches = 0;
        endfunction

        // an input transaction was accepted: update the store, queue its result
        function void note_item(logic op, int value);
            queue_result_t r;
            int            pos;
            r.status        = sipq_pkg::ST_DONE;
            r.removed_value = '0;
            if (op == sipq_pkg::OP_INSERT) begin
                if (held_values.size() >= capacity) begin
                    r.status = sipq_pkg::ST_FULL;
                end else begin
                    // new value goes in front of the first one not smaller
                    pos = 0;
                    while (pos < held_values.size() && held_values[pos] < value)
                        pos++;
                    held_values.insert(pos, value);
                end
            end else begin
                if (held_values.size() == 0) begin
                    r.status = sipq_pkg::ST_EMPTY;
                end else begin
                    r.removed_value = held_values.pop_front();
                end
            end
            r.entry_count = count_t'(held_values.size());
            awaited_results.push_back(r);
        endfunction

        // a result transaction was accepted: compare with the oldest prediction
        function void check_result(sipq_pkg::status_t status, sipq_pkg::value_t removed,
                                   count_t count);
            queue_result_t want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d removed %0d count %0d",
                             status, $signed(removed), count);
                return;
            end
            want = awaited_results.pop_front();
            if (status !== want.status || removed !== want.removed_value ||
                    count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want st %0d val %0d cnt %0d, got st %0d val %0d cnt %0d",
                             want.status, $signed(want.removed_value), want.entry_count,
                             status, $signed(removed), count);
            end
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction
    endclass

    logic                                 aclk;
    logic                                 aresetn = 1'b0;

    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic                                 s_op    = sipq_pkg::OP_INSERT;
    logic signed [sipq_pkg::VALUE_W-1:0]  s_value = '0;

    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [sipq_pkg::STATUS_W-1:0]        m_status;
    logic signed [sipq_pkg::VALUE_W-1:0]  m_removed_value;
    logic [sipq_pkg::ENTRY_COUNT_W-1:0]   m_entry_count;

    // set during the stretch where neither side idles
    bit calm = 1'b0;

    sorted_store_tracker store = new(CAPACITY);

    sorted_insert_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_entry_count   (m_entry_count)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(2_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // result monitor, sampled on the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            store.check_result(m_status, m_removed_value, m_entry_count);
    end

    // present one input transaction, with a random idle gap in front of it,
    // and return at the rising edge where it is accepted
    task automatic send_item(input logic op, input int value);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        // back-to-back transactions keep valid high, only the payload moves
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        store.note_item(op, value);
    endtask

    // stop sending and hold off until every predicted result has come back
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (store.outstanding() != 0) @(posedge aclk);
    endtask

    // values biased toward extremes and a narrow band that makes ties likely
    function automatic int pick_value();
        int v;
        case ($urandom_range(9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2, 3, 4: v = int'($urandom_range(8)) - 4;
            5:       v = int'($urandom_range(15)) << 28;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        int   sent;
        int   phase_left;
        int   phase_kind;
        logic op;

        // reset held low from the start, released on a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: remove on empty, extremes, ties, then drain past empty
        send_item(sipq_pkg::OP_REMOVE, 32'h1234_5678);
        send_item(sipq_pkg::OP_INSERT, 32'h7fff_ffff);
        send_item(sipq_pkg::OP_INSERT, 32'h8000_0000);
        send_item(sipq_pkg::OP_INSERT, 0);
        send_item(sipq_pkg::OP_INSERT, -1);
        send_item(sipq_pkg::OP_INSERT, 0);
        send_item(sipq_pkg::OP_INSERT, 32'h7fff_ffff);
        send_item(sipq_pkg::OP_INSERT, 32'h8000_0000);
        repeat (8) send_item(sipq_pkg::OP_REMOVE, $urandom);

        // random part in phases: filling (mostly inserts), draining (mostly
        // removes) and mixed, each with random content
        sent       = 0;
        phase_left = 0;
        phase_kind = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                phase_kind = $urandom_range(2);
                phase_left = $urandom_range(40, 10);
            end
            calm = (sent >= 150 && sent < 260);
            if (sent == 400)
                wait_for_drain();
            case (phase_kind)
                0:       op = ($urandom_range(99) < 85) ? sipq_pkg::OP_INSERT
                                                        : sipq_pkg::OP_REMOVE;
                1:       op = ($urandom_range(99) < 85) ? sipq_pkg::OP_REMOVE
                                                        : sipq_pkg::OP_INSERT;
                default: op = 1'($urandom_range(1));
            endcase
            send_item(op, pick_value());
            sent++;
            phase_left--;
        end
        calm = 1'b0;

        // all input accepted, let the remaining results come out
        @(negedge aclk);
        s_valid <= 1'b0;
        while (store.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (store.mismatches == 0 && store.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/sipq_pkg.sv
hdl/sipq_ram.sv
hdl/sorted_insert_priority_queue_core.sv
tb/tb_top.sv
